FILE: design/xcs_pkg.sv
package xcs_pkg;

    localparam int SET_DEPTH_DEF = 64;
    localparam int WORD_BITS_DEF = 16;
    localparam int FIELD_BITS = 16;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  xor_count;
        logic [15:0] term_first;
        logic [15:0] term_second;
        logic [15:0] term_third;
        logic [15:0] term_fourth;
    } t_out_item;

endpackage

FILE: design/xcs_stream_if.sv
interface xcs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/xcs_ram.sv
module xcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write one port, registered read on the other
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/xor_combination_search.sv
// xor_combination_search
// Holds a sorted set of distinct words in one RAM and answers three kinds of
// item on the input channel: clear the set, insert a word, or query a word x.
// A query reports the first combination of one to four members whose XOR is
// x, walking members in ascending order; one result leaves on the output
// channel for every input item.
// One item is worked at a time. Every member lookup is a linear scan of the
// RAM through its single read port, and each walked member is fetched through
// S_FETCH, S_FWAIT and S_FWAIT2, so timing follows the set size n.
// An insert scans for a duplicate, finds its position, then shifts members
// up; the run time of a query is dominated by the lookup scan inside the
// triple walk.
// The result sits in an output register; the block holds it while the
// receiver stalls and takes the next item the cycle after the result is taken.
// Reset empties the set (count to zero) at once; RAM contents stay as they
// are and are never read above the count.
module xor_combination_search #(
    parameter int SET_DEPTH = xcs_pkg::SET_DEPTH_DEF,
    parameter int WORD_BITS = xcs_pkg::WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    xcs_stream_if.sink   i_in,
    xcs_stream_if.source o_out
);
    import xcs_pkg::*;

    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOOKUP = 10'b0000000010,  // scan for r_probe
        S_LKWAIT = 10'b0000000100,
        S_FETCH  = 10'b0000001000,  // read walked member
        S_FWAIT  = 10'b0000010000,
        S_INSPOS = 10'b0000100000,  // find insert position
        S_SHIFT  = 10'b0001000000,
        S_SHWR   = 10'b0010000000,
        S_DONE   = 10'b0100000000,
        S_FWAIT2 = 10'b1000000000
    } t_state;

    t_state               r_state;
    logic [WORD_BITS-1:0] r_x, r_probe;
    logic [WORD_BITS-1:0] r_mi, r_mj, r_mk;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_scan;     // lookup / position scan index
    logic [CW-1:0]        r_pos;      // insert position
    logic [CW-1:0]        r_i, r_j, r_k;
    logic [1:0]           r_terms;    // terms minus one being searched
    logic [1:0]           r_fsel;     // which walked index to fetch
    logic                 r_ins;      // item is insert
    logic                 r_rvalid;   // read data belongs to r_scan-1
    t_out_item            r_res;
    logic                 r_ovalid;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;

    xcs_ram #(.WIDTH(WORD_BITS), .DEPTH(SET_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign i_in.ready    = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_res;

    function automatic logic [FIELD_BITS-1:0] fld(input logic [WORD_BITS-1:0] v);
        logic [FIELD_BITS+WORD_BITS-1:0] t;
        t = {{FIELD_BITS{1'b0}}, v};
        return t[FIELD_BITS-1:0];
    endfunction

    // combinational control
    logic [WORD_BITS-1:0] cand;
    logic [CW-1:0]        fidx;
    always_comb begin
        we    = 1'b0;
        waddr = r_scan[AW-1:0];
        wdata = rdata;
        raddr = r_scan[AW-1:0];
        fidx  = r_i;
        unique case (r_fsel)
            2'd0:    fidx = r_i;
            2'd1:    fidx = r_j;
            default: fidx = r_k;
        endcase
        if (r_state == S_FETCH || r_state == S_FWAIT) raddr = fidx[AW-1:0];
        if (r_state == S_SHIFT) raddr = AW'(r_scan - 1'b1);
        if (r_state == S_SHWR) begin
            we = 1'b1;
            // the last write of the shift places the new word
            if (r_rvalid) wdata = r_x;
        end
        // candidate probe for the next combination
        unique case (r_terms)
            2'd1:    cand = r_x ^ r_mi;
            2'd2:    cand = r_x ^ r_mi ^ r_mj;
            default: cand = r_x ^ r_mi ^ r_mj ^ r_mk;
        endcase
    end

    // advance to the next walked combination; returns 1 if it exists
    logic          adv_ok;
    logic [CW-1:0] a_i, a_j, a_k;
    logic [1:0]    a_terms;
    always_comb begin
        a_i = r_i; a_j = r_j; a_k = r_k; a_terms = r_terms;
        adv_ok = 1'b1;
        priority if (r_terms == 2'd1) begin
            a_i = r_i + 1'b1;
        end else if (r_terms == 2'd2) begin
            a_j = r_j + 1'b1;
            if (a_j >= r_cnt) begin
                a_i = r_i + 1'b1;
                a_j = CW'(r_i + 2'd2);
            end
        end else begin
            a_k = r_k + 1'b1;
            if (a_k >= r_cnt) begin
                a_j = r_j + 1'b1;
                a_k = CW'(r_j + 2'd2);
                if (a_k >= r_cnt) begin
                    a_i = r_i + 1'b1;
                    a_j = CW'(r_i + 2'd2);
                    a_k = CW'(r_i + 2'd3);
                end
            end
        end
        // level exhausted: move to the next term count
        if ((r_terms == 2'd1 && a_i >= r_cnt) ||
            (r_terms == 2'd2 && (a_i >= r_cnt || a_j >= r_cnt)) ||
            (r_terms == 2'd3 && (a_i >= r_cnt || a_j >= r_cnt || a_k >= r_cnt))) begin
            a_i = '0; a_j = CW'(1); a_k = CW'(2);
            if (r_terms == 2'd3) adv_ok = 1'b0;
            a_terms = r_terms + 1'b1;
            if (a_terms == 2'd2 && r_cnt < CW'(2)) adv_ok = 1'b0;
            if (a_terms == 2'd3 && r_cnt < CW'(3)) adv_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            // drop result once taken
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && !r_ovalid) begin
                        r_x      <= WORD_BITS'(i_in.payload.word);
                        r_probe  <= WORD_BITS'(i_in.payload.word);
                        r_scan   <= '0;
                        r_rvalid <= 1'b0;
                        r_terms  <= 2'd0;
                        r_ins    <= i_in.payload.action == ACT_INSERT;
                        if (i_in.payload.action[1] || i_in.payload.action == ACT_INSERT) begin
                            r_res   <= '0;
                            r_state <= S_LOOKUP;
                        end else begin
                            r_cnt   <= '0;
                            r_res   <= {ST_CLEARED, {($bits(t_out_item) - 3){1'b0}}};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_LOOKUP: begin
                    // linear scan: read r_scan, compare previous read
                    if (r_rvalid && rdata == r_probe) begin
                        r_rvalid <= 1'b0;
                        if (r_ins) begin
                            r_res.status <= ST_DUPLICATE;
                            r_state      <= S_DONE;
                        end else begin
                            r_res.status    <= ST_FOUND;
                            r_res.xor_count <= r_terms;
                            unique case (r_terms)
                                2'd0: r_res.term_first <= fld(r_x);
                                2'd1: begin
                                    r_res.term_first  <= fld(r_mi);
                                    r_res.term_second <= fld(r_probe);
                                end
                                2'd2: begin
                                    r_res.term_first  <= fld(r_mi);
                                    r_res.term_second <= fld(r_mj);
                                    r_res.term_third  <= fld(r_probe);
                                end
                                default: begin
                                    r_res.term_first  <= fld(r_mi);
                                    r_res.term_second <= fld(r_mj);
                                    r_res.term_third  <= fld(r_mk);
                                    r_res.term_fourth <= fld(r_probe);
                                end
                            endcase
                            r_state <= S_DONE;
                        end
                    end else if (r_scan >= r_cnt) begin
                        r_rvalid <= 1'b0;
                        if (r_ins) begin
                            if (r_cnt == CW'(SET_DEPTH)) begin
                                r_res.status <= ST_FULL;
                                r_state      <= S_DONE;
                            end else begin
                                r_scan  <= '0;
                                r_state <= S_INSPOS;
                            end
                        end else if (r_terms == 2'd0) begin
                            // start two-term walk
                            r_terms <= 2'd1;
                            r_i <= '0; r_j <= CW'(1); r_k <= CW'(2);
                            r_fsel <= 2'd0;
                            if (r_cnt == '0) begin
                                r_res.status <= ST_NOT_FOUND;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_FETCH;
                            end
                        end else if (adv_ok) begin
                            r_i <= a_i; r_j <= a_j; r_k <= a_k;
                            r_terms <= a_terms;
                            r_fsel  <= 2'd0;
                            r_state <= S_FETCH;
                        end else begin
                            r_res.status <= ST_NOT_FOUND;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_scan   <= r_scan + 1'b1;
                        r_rvalid <= 1'b1;
                    end
                end
                S_FETCH: begin
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    r_state <= S_FWAIT2;
                end
                S_FWAIT2: begin
                    // latch fetched member, then the next or start lookup
                    unique case (r_fsel)
                        2'd0:    r_mi <= rdata;
                        2'd1:    r_mj <= rdata;
                        default: r_mk <= rdata;
                    endcase
                    if (r_fsel < r_terms - 1'b1) begin
                        r_fsel  <= r_fsel + 1'b1;
                        r_state <= S_FETCH;
                    end else begin
                        r_state <= S_INSPOS;  // reuse as probe build step
                    end
                end
                S_INSPOS: begin
                    if (!r_ins) begin
                        // build probe from fetched members, then scan
                        r_probe  <= cand;
                        r_scan   <= '0;
                        r_rvalid <= 1'b0;
                        r_state  <= S_LOOKUP;
                    end else if (r_rvalid && !(rdata < r_x)) begin
                        // position found at r_scan-1; shift from top
                        r_rvalid <= 1'b0;
                        r_pos    <= r_scan - 1'b1;
                        r_scan   <= r_cnt;
                        r_state  <= S_SHIFT;
                    end else if (r_scan >= r_cnt) begin
                        r_rvalid <= 1'b0;
                        r_pos    <= r_cnt;
                        r_scan   <= r_cnt;
                        r_state  <= S_SHIFT;
                    end else begin
                        r_scan   <= r_scan + 1'b1;
                        r_rvalid <= 1'b1;
                    end
                end
                S_SHIFT: begin
                    // r_pos holds insert position
                    if (r_scan == r_pos) begin
                        r_state <= S_SHWR;
                        r_rvalid <= 1'b1;  // marks final word write
                    end else begin
                        r_rvalid <= 1'b0;
                        r_state  <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    if (r_rvalid) begin
                        r_cnt        <= r_cnt + 1'b1;
                        r_res.status <= ST_INSERTED;
                        r_rvalid     <= 1'b0;
                        r_state      <= S_DONE;
                    end else begin
                        r_scan  <= r_scan - 1'b1;
                        r_state <= S_SHIFT;
                    end
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
